// File: design/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, masked during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/rtfs_pkg.sv
package rtfs_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int OUT_LEN_W       = 16;

    // output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FILL_W     = 3;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SLASH  = 8'h5C;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_HT     = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // progress of the backslash-tab match window
    typedef enum logic [1:0] {
        MATCH_NONE,
        MATCH_SLASH,
        MATCH_T,
        MATCH_TA
    } t_match;

    typedef struct packed {
        logic [7:0]           out_char;
        logic                 last;
        logic [OUT_LEN_W-1:0] out_length;
    } t_result;

endpackage

// File: design/rtfs_if.sv
interface rtfs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       end_of_text;

    modport source (output valid, output in_char, output end_of_text, input ready);
    modport sink   (input valid, input in_char, input end_of_text, output ready);
endinterface

interface rtfs_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_char;
    logic        last;
    logic [15:0] out_length;

    modport source (output valid, output out_char, output last, output out_length,
                    input ready);
    modport sink   (input valid, input out_char, input last, input out_length,
                    output ready);
endinterface

// File: design/rtf_code_stripper.sv
// a result is registered into the output queue and offered once earlier results drain
// throughput: one input byte per cycle while ready; a byte giving the prefix brace and
//   its character puts two results into the 4-entry output queue, which drains one
//   result per cycle while o_out.ready; input ready needs at least two free entries
// reset (synchronous, active low) clears all stream state, the queue and keep_prefix
`include "assert_macros.svh"

module rtf_code_stripper #(
    parameter int LENGTH_BITS = rtfs_pkg::LENGTH_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    rtfs_in_if.sink       i_in,
    rtfs_out_if.source    o_out
);

    localparam logic [LENGTH_BITS-1:0] CNT_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [rtfs_pkg::FILL_W-1:0] FILL_LIMIT =
        rtfs_pkg::FILL_W'(rtfs_pkg::FIFO_DEPTH - 2);

    logic                 r_keep_prefix;
    logic                 r_in_brace,    n_in_brace;
    logic                 r_after_slash, n_after_slash;
    logic                 r_seen_first,  n_seen_first;
    logic                 r_prev_space,  n_prev_space;
    logic [LENGTH_BITS-1:0] r_count,     n_count;
    rtfs_pkg::t_match     r_match,       n_match;

    rtfs_pkg::t_result    r_fifo [rtfs_pkg::FIFO_DEPTH];
    logic [rtfs_pkg::FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [rtfs_pkg::FILL_W-1:0]  r_fill,   n_fill;

    rtfs_pkg::t_result    em [2];
    logic [1:0]           em_n;
    logic                 in_fire, out_fire;
    logic [LENGTH_BITS+15:0] cnt_ext;
    logic [15:0]          len16;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    assign i_in.ready = (r_fill <= FILL_LIMIT);

    // clamp the running count to the 16-bit output field
    assign cnt_ext = {16'b0, r_count};
    assign len16   = (cnt_ext[LENGTH_BITS+15:16] != '0) ? 16'hFFFF : cnt_ext[15:0];

    always_comb begin
        logic       as, ib, sf, pv, white, do_start;
        logic [7:0] c;
        logic [LENGTH_BITS-1:0] cnt;
        logic       cv [2];
        logic [7:0] cc [2];

        c        = i_in.in_char;
        as       = r_after_slash;
        ib       = r_in_brace;
        sf       = r_seen_first;
        pv       = r_prev_space;
        cnt      = r_count;
        n_match  = r_match;
        do_start = 1'b0;
        cv[0]    = 1'b0;
        cv[1]    = 1'b0;
        cc[0]    = rtfs_pkg::CH_NUL;
        cc[1]    = rtfs_pkg::CH_NUL;
        em[0]    = '0;
        em[1]    = '0;
        em_n     = 2'd0;
        white    = (c == rtfs_pkg::CH_SPACE) || (c >= rtfs_pkg::CH_HT && c <= rtfs_pkg::CH_CR);

        if (in_fire && i_in.end_of_text) begin
            // a pending backslash resolves without output, so only the terminator leaves
            em[0]    = '{out_char: rtfs_pkg::CH_NUL, last: 1'b1, out_length: len16};
            em_n     = 2'd1;
            as       = 1'b0;
            ib       = 1'b0;
            sf       = 1'b0;
            pv       = 1'b0;
            cnt      = '0;
            n_match  = rtfs_pkg::MATCH_NONE;
        end else if (in_fire && c != rtfs_pkg::CH_NUL) begin
            unique case (r_match)
                rtfs_pkg::MATCH_NONE: do_start = 1'b1;
                rtfs_pkg::MATCH_SLASH: begin
                    if (c == rtfs_pkg::CH_T) n_match = rtfs_pkg::MATCH_T;
                    else do_start = 1'b1;
                end
                rtfs_pkg::MATCH_T: begin
                    if (c == rtfs_pkg::CH_A) n_match = rtfs_pkg::MATCH_TA;
                    else do_start = 1'b1;
                end
                rtfs_pkg::MATCH_TA: begin
                    if (c == rtfs_pkg::CH_B) begin
                        n_match = rtfs_pkg::MATCH_NONE;
                        cv[0]   = 1'b1;
                        cc[0]   = rtfs_pkg::CH_SPACE;
                        as      = 1'b1;
                    end else begin
                        do_start = 1'b1;
                    end
                end
                default: do_start = 1'b1;
            endcase

            // mismatch: held letters fall inside the now open control word
            if (do_start && r_match != rtfs_pkg::MATCH_NONE) begin
                as      = 1'b1;
                n_match = rtfs_pkg::MATCH_NONE;
            end

            if (do_start) begin
                if (c == rtfs_pkg::CH_SLASH) begin
                    n_match = rtfs_pkg::MATCH_SLASH;
                end else if (c == rtfs_pkg::CH_LBRACE) begin
                    ib = 1'b1;
                    as = 1'b0;
                end else if (c == rtfs_pkg::CH_RBRACE) begin
                    ib = 1'b0;
                    as = 1'b0;
                end else begin
                    if (white) as = 1'b0;
                    if (!(white && !sf) && !as && !ib) begin
                        if (!sf) begin
                            cv[0] = r_keep_prefix;
                            cc[0] = rtfs_pkg::CH_LBRACE;
                            sf    = 1'b1;
                        end
                        cv[1] = 1'b1;
                        cc[1] = c;
                    end
                end
            end

            // space collapsing and saturating count
            for (int i = 0; i < 2; i++) begin
                if (cv[i] && !(cc[i] == rtfs_pkg::CH_SPACE && pv)) begin
                    pv = (cc[i] == rtfs_pkg::CH_SPACE);
                    em[em_n[0]] = '{out_char: cc[i], last: 1'b0, out_length: 16'd0};
                    em_n = em_n + 2'd1;
                    if (cnt != CNT_MAX) cnt = cnt + 1'b1;
                end
            end
        end

        n_after_slash = as;
        n_in_brace    = ib;
        n_seen_first  = sf;
        n_prev_space  = pv;
        n_count       = cnt;
        n_fill        = r_fill + rtfs_pkg::FILL_W'(em_n) - rtfs_pkg::FILL_W'(out_fire);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_prefix <= 1'b0;
            r_in_brace    <= 1'b0;
            r_after_slash <= 1'b0;
            r_seen_first  <= 1'b0;
            r_prev_space  <= 1'b0;
            r_count       <= '0;
            r_match       <= rtfs_pkg::MATCH_NONE;
            r_wr_ptr      <= '0;
            r_rd_ptr      <= '0;
            r_fill        <= '0;
        end else begin
            if (i_cfg_we) r_keep_prefix <= i_cfg_wdata;
            r_in_brace    <= n_in_brace;
            r_after_slash <= n_after_slash;
            r_seen_first  <= n_seen_first;
            r_prev_space  <= n_prev_space;
            r_count       <= n_count;
            r_match       <= n_match;
            r_wr_ptr      <= r_wr_ptr + rtfs_pkg::FIFO_AW'(em_n);
            if (out_fire) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_fill        <= n_fill;
        end
    end

    // queue payload, no reset
    always_ff @(posedge i_clk) begin
        if (em_n != 2'd0) r_fifo[r_wr_ptr] <= em[0];
        if (em_n == 2'd2) r_fifo[r_wr_ptr + 1'b1] <= em[1];
    end

    assign o_out.valid      = (r_fill != '0);
    assign o_out.out_char   = r_fifo[r_rd_ptr].out_char;
    assign o_out.last       = r_fifo[r_rd_ptr].last;
    assign o_out.out_length = r_fifo[r_rd_ptr].out_length;

    `ASSERT_IMPLIES(a_no_overflow, i_clk, i_rst_n, in_fire, r_fill <= FILL_LIMIT)
    `ASSERT_IMPLIES(a_term_char, i_clk, i_rst_n, o_out.valid && o_out.last,
                    o_out.out_char == rtfs_pkg::CH_NUL)
    `ASSERT_IMPLIES(a_len_only_last, i_clk, i_rst_n, o_out.valid && !o_out.last,
                    o_out.out_length == 16'd0)
    `ASSERT_NEXT(a_eot_clears, i_clk, i_rst_n, in_fire && i_in.end_of_text,
                 r_match == rtfs_pkg::MATCH_NONE && !r_seen_first && r_count == '0)

endmodule

// File: sim/tb_rtf_code_stripper.sv
module tb_rtf_code_stripper;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;

    class strip_scoreboard;
        rtfs_pkg::t_result expected_q[$];
        int                err_count;
        bit                keep_prefix;
        bit                in_brace;
        bit                after_slash;
        bit                seen_first;
        bit                prev_space;
        rtfs_pkg::t_match  match_state;
        logic [15:0]       char_count;

        function new();
            err_count   = 0;
            keep_prefix = 1'b0;
            clear_stream();
        endfunction

        function void clear_stream();
            in_brace    = 1'b0;
            after_slash = 1'b0;
            seen_first  = 1'b0;
            prev_space  = 1'b0;
            match_state = rtfs_pkg::MATCH_NONE;
            char_count  = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void put(logic [7:0] c, logic lst, logic [15:0] len);
            rtfs_pkg::t_result r;
            r.out_char   = c;
            r.last       = lst;
            r.out_length = len;
            expected_q.push_back(r);
        endfunction

        // space run collapsing and length count
        function void emit(logic [7:0] c);
            if (c == rtfs_pkg::CH_SPACE && prev_space)
                return;
            prev_space = (c == rtfs_pkg::CH_SPACE);
            put(c, 1'b0, '0);
            if (char_count != 16'hFFFF)
                char_count++;
        endfunction

        function bit is_white(logic [7:0] c);
            return c == rtfs_pkg::CH_SPACE || (c >= rtfs_pkg::CH_HT && c <= rtfs_pkg::CH_CR);
        endfunction

        function void plain(logic [7:0] c);
            if (c == rtfs_pkg::CH_LBRACE) begin
                in_brace    = 1'b1;
                after_slash = 1'b0;
                return;
            end
            if (c == rtfs_pkg::CH_RBRACE) begin
                in_brace    = 1'b0;
                after_slash = 1'b0;
                return;
            end
            if (is_white(c)) begin
                after_slash = 1'b0;
                if (!seen_first)
                    return;
            end
            if (!after_slash && !in_brace) begin
                if (!seen_first) begin
                    if (keep_prefix)
                        emit(rtfs_pkg::CH_LBRACE);
                    seen_first = 1'b1;
                end
                emit(c);
            end
        endfunction

        function void start(logic [7:0] c);
            if (c == rtfs_pkg::CH_SLASH)
                match_state = rtfs_pkg::MATCH_SLASH;
            else
                plain(c);
        endfunction

        // held backslash turns into a control word, held letters replay
        function void drop_window();
            rtfs_pkg::t_match held;
            held        = match_state;
            match_state = rtfs_pkg::MATCH_NONE;
            after_slash = 1'b1;
            if (held == rtfs_pkg::MATCH_T || held == rtfs_pkg::MATCH_TA)
                plain(rtfs_pkg::CH_T);
            if (held == rtfs_pkg::MATCH_TA)
                plain(rtfs_pkg::CH_A);
        endfunction

        function void feed(logic [7:0] c);
            logic [7:0] want;
            case (match_state)
                rtfs_pkg::MATCH_SLASH: want = rtfs_pkg::CH_T;
                rtfs_pkg::MATCH_T:     want = rtfs_pkg::CH_A;
                default:               want = rtfs_pkg::CH_B;
            endcase
            if (match_state == rtfs_pkg::MATCH_NONE) begin
                start(c);
            end else if (c == want) begin
                if (match_state == rtfs_pkg::MATCH_TA) begin
                    match_state = rtfs_pkg::MATCH_NONE;
                    emit(rtfs_pkg::CH_SPACE);
                    after_slash = 1'b1;
                end else if (match_state == rtfs_pkg::MATCH_SLASH) begin
                    match_state = rtfs_pkg::MATCH_T;
                end else begin
                    match_state = rtfs_pkg::MATCH_TA;
                end
            end else begin
                drop_window();
                start(c);
            end
        endfunction

        function void note_input(logic [7:0] c, logic eot);
            if (eot) begin
                if (match_state != rtfs_pkg::MATCH_NONE)
                    drop_window();
                put(rtfs_pkg::CH_NUL, 1'b1, char_count);
                clear_stream();
            end else if (c != rtfs_pkg::CH_NUL) begin
                feed(c);
            end
        endfunction

        task report(string msg);
            err_count++;
            $display("tb: mismatch: %s", msg);
        endtask

        task check_result(rtfs_pkg::t_result got);
            rtfs_pkg::t_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("result char %0h last %0b with nothing expected",
                                 got.out_char, got.last));
                return;
            end
            want = expected_q.pop_front();
            if (got.out_char !== want.out_char)
                report($sformatf("out_char got %0h expected %0h", got.out_char,
                                 want.out_char));
            if (got.last !== want.last)
                report($sformatf("last got %0b expected %0b", got.last, want.last));
            if (got.out_length !== want.out_length)
                report($sformatf("out_length got %0d expected %0d", got.out_length,
                                 want.out_length));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic cfg_wdata;

    rtfs_in_if  in_if ();
    rtfs_out_if out_if ();

    strip_scoreboard sb;
    int item_count;
    bit tx_calm;
    bit rx_calm;

    rtf_code_stripper dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // scoreboard sees every transaction on both channels at the clock edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                sb.note_input(in_if.in_char, in_if.end_of_text);
            if (out_if.valid && out_if.ready)
                sb.check_result(rtfs_pkg::t_result'({out_if.out_char, out_if.last,
                                                     out_if.out_length}));
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb_rtf_code_stripper: FAIL");
        $finish;
    end

    // output sink with random stalls
    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 29) == 0)
                rx_calm = !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
        end
    end

    task automatic send_byte(input logic [7:0] ch, input logic eot);
        int gap;
        if ($urandom_range(0, 24) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.in_char     <= ch;
        in_if.end_of_text <= eot;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        if (eot || ch != rtfs_pkg::CH_NUL)
            item_count++;
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_keep_prefix(input bit v);
        drain_results();
        // bytes that give no result may still be in flight
        repeat (4) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.keep_prefix = v;
    endtask

    function automatic logic [7:0] rand_letter();
        case ($urandom_range(0, 3))
            0:       return rtfs_pkg::CH_T;
            1:       return rtfs_pkg::CH_A;
            2:       return rtfs_pkg::CH_B;
            default: return 8'(8'h61 + $urandom_range(0, 25));
        endcase
    endfunction

    task automatic send_fragment();
        int kind;
        int n;
        kind = $urandom_range(0, 15);
        case (kind)
            0, 1, 2: begin
                n = $urandom_range(1, 6);
                repeat (n) send_byte(rand_letter(), 1'b0);
            end
            3, 4: begin
                n = $urandom_range(1, 3);
                repeat (n)
                    send_byte(($urandom_range(0, 2) == 0)
                              ? 8'($urandom_range(rtfs_pkg::CH_HT, rtfs_pkg::CH_CR))
                              : rtfs_pkg::CH_SPACE, 1'b0);
            end
            5, 6: begin
                send_byte(rtfs_pkg::CH_SLASH, 1'b0);
                send_byte(rtfs_pkg::CH_T, 1'b0);
                send_byte(rtfs_pkg::CH_A, 1'b0);
                send_byte(rtfs_pkg::CH_B, 1'b0);
            end
            7: begin
                send_byte(rtfs_pkg::CH_SLASH, 1'b0);
                n = $urandom_range(1, 4);
                repeat (n) send_byte(rand_letter(), 1'b0);
                if ($urandom_range(0, 1))
                    send_byte(rtfs_pkg::CH_SPACE, 1'b0);
            end
            8: begin
                // broken tab sequence
                send_byte(rtfs_pkg::CH_SLASH, 1'b0);
                send_byte(rtfs_pkg::CH_T, 1'b0);
                if ($urandom_range(0, 1))
                    send_byte(rtfs_pkg::CH_A, 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            9: begin
                send_byte(rtfs_pkg::CH_LBRACE, 1'b0);
                n = $urandom_range(0, 3);
                repeat (n) send_byte(rand_letter(), 1'b0);
                if ($urandom_range(0, 1)) begin
                    send_byte(rtfs_pkg::CH_SLASH, 1'b0);
                    send_byte(rtfs_pkg::CH_T, 1'b0);
                    send_byte(rtfs_pkg::CH_A, 1'b0);
                    send_byte(rtfs_pkg::CH_B, 1'b0);
                end
                send_byte(rtfs_pkg::CH_RBRACE, 1'b0);
            end
            10: send_byte($urandom_range(0, 1) ? rtfs_pkg::CH_LBRACE : rtfs_pkg::CH_RBRACE,
                          1'b0);
            11: send_byte(rtfs_pkg::CH_NUL, 1'b0);
            12, 13: send_byte(8'($urandom_range(0, 255)), 1'b0);
            14: send_byte(8'($urandom_range(0, 255)), 1'b1);
            default: begin
                send_byte(rtfs_pkg::CH_SLASH, 1'b0);
                if ($urandom_range(0, 1))
                    send_byte(rtfs_pkg::CH_SLASH, 1'b0);
                else
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
    endtask

    task automatic random_phase(input int count);
        int first;
        bit paused;
        first  = item_count;
        paused = 1'b0;
        while (item_count - first < count) begin
            send_fragment();
            if ((!paused && item_count - first >= count / 2) || $urandom_range(0, 59) == 0) begin
                drain_results();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        sb         = new();
        item_count = 0;
        tx_calm    = 1'b0;
        rx_calm    = 1'b0;
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.in_char     <= '0;
        in_if.end_of_text <= 1'b0;
        out_if.ready      <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // leading white space, tab before the first character, groups, control words
        send_byte(rtfs_pkg::CH_SPACE, 1'b0);
        send_byte(rtfs_pkg::CH_HT, 1'b0);
        send_byte(rtfs_pkg::CH_SLASH, 1'b0);
        send_byte(rtfs_pkg::CH_T, 1'b0);
        send_byte(rtfs_pkg::CH_A, 1'b0);
        send_byte(rtfs_pkg::CH_B, 1'b0);
        send_byte(rtfs_pkg::CH_SPACE, 1'b0);
        send_byte(8'h48, 1'b0);
        send_byte(rtfs_pkg::CH_NUL, 1'b0);
        send_byte(rtfs_pkg::CH_LBRACE, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(rtfs_pkg::CH_RBRACE, 1'b0);
        send_byte(rtfs_pkg::CH_SLASH, 1'b0);
        send_byte(8'h70, 1'b0);
        send_byte(rtfs_pkg::CH_SPACE, 1'b0);
        send_byte(rtfs_pkg::CH_SPACE, 1'b0);
        send_byte(rtfs_pkg::CH_SLASH, 1'b0);
        send_byte(rtfs_pkg::CH_T, 1'b0);
        send_byte(8'h71, 1'b0);
        send_byte(rtfs_pkg::CH_CR, 1'b0);
        send_byte(8'hFF, 1'b0);
        // backslash still held at end of text
        send_byte(rtfs_pkg::CH_SLASH, 1'b0);
        send_byte(8'hA5, 1'b1);
        send_byte(rtfs_pkg::CH_NUL, 1'b1);

        write_keep_prefix(1'b1);
        send_byte(rtfs_pkg::CH_SPACE, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(rtfs_pkg::CH_NUL, 1'b1);
        random_phase(80);

        write_keep_prefix(1'b0);
        random_phase(80);

        write_keep_prefix(1'b1);
        random_phase(80);

        drain_results();
        repeat (10) @(posedge i_clk);
        if (sb.err_count == 0 && sb.pending() == 0)
            $display("tb_rtf_code_stripper: PASS");
        else
            $display("tb_rtf_code_stripper: FAIL");
        $finish;
    end

endmodule
